FILE: hdl/mfde_pkg.sv
// Package for the monochrome frame buffer draw engine: panel geometry,
// command and state codes, and the 5x7 font table.
// No dependencies.
package mfde_pkg;

	localparam int PANEL_WIDTH = 128;
	localparam int PANEL_HEIGHT = 64;
	localparam int PAGE_COUNT = (PANEL_HEIGHT + 7) / 8;
	localparam int STORE_SIZE = PANEL_WIDTH * PAGE_COUNT;
	localparam int ADDR_W = $clog2(STORE_SIZE);
	localparam int COL_W = $clog2(PANEL_WIDTH);
	localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int CRD_W = 12;
	localparam logic [7:0] FIRST_CODE = 8'h20;
	localparam logic [7:0] LAST_CODE = 8'h7E;
	localparam int CELL_COLS = 6;
	localparam logic [7:0] SPACING_BITS = 8'h00;

	typedef enum logic [2:0] {
		FN_PIXEL,
		FN_CHAR,
		FN_CHAR_INV,
		FN_CHAR_DBL,
		FN_FILL,
		FN_CLEAR,
		FN_READ,
		FN_NONE
	} func_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD,
		ST_WR,
		ST_DONE
	} state_t;

	// Column 0 of the glyph sits in bits 39:32, column 4 in bits 7:0.
	function automatic logic [39:0] font_glyph(input logic [7:0] c);
		logic [39:0] g;
		begin
			case (c)
				8'h20: g = {8'h00,8'h00,8'h00,8'h00,8'h00};
				8'h21: g = {8'h00,8'h00,8'h5f,8'h00,8'h00};
				8'h22: g = {8'h00,8'h07,8'h00,8'h07,8'h00};
				8'h23: g = {8'h14,8'h7f,8'h14,8'h7f,8'h14};
				8'h24: g = {8'h24,8'h2a,8'h7f,8'h2a,8'h12};
				8'h25: g = {8'h23,8'h13,8'h08,8'h64,8'h62};
				8'h26: g = {8'h36,8'h49,8'h55,8'h22,8'h50};
				8'h27: g = {8'h00,8'h05,8'h03,8'h00,8'h00};
				8'h28: g = {8'h00,8'h1c,8'h22,8'h41,8'h00};
				8'h29: g = {8'h00,8'h41,8'h22,8'h1c,8'h00};
				8'h2a: g = {8'h14,8'h08,8'h3e,8'h08,8'h14};
				8'h2b: g = {8'h08,8'h08,8'h3e,8'h08,8'h08};
				8'h2c: g = {8'h00,8'h50,8'h30,8'h00,8'h00};
				8'h2d: g = {8'h08,8'h08,8'h08,8'h08,8'h08};
				8'h2e: g = {8'h00,8'h60,8'h60,8'h00,8'h00};
				8'h2f: g = {8'h20,8'h10,8'h08,8'h04,8'h02};
				8'h30: g = {8'h3e,8'h51,8'h49,8'h45,8'h3e};
				8'h31: g = {8'h00,8'h42,8'h7f,8'h40,8'h00};
				8'h32: g = {8'h42,8'h61,8'h51,8'h49,8'h46};
				8'h33: g = {8'h21,8'h41,8'h45,8'h4b,8'h31};
				8'h34: g = {8'h18,8'h14,8'h12,8'h7f,8'h10};
				8'h35: g = {8'h27,8'h45,8'h45,8'h45,8'h39};
				8'h36: g = {8'h3c,8'h4a,8'h49,8'h49,8'h30};
				8'h37: g = {8'h01,8'h71,8'h09,8'h05,8'h03};
				8'h38: g = {8'h36,8'h49,8'h49,8'h49,8'h36};
				8'h39: g = {8'h06,8'h49,8'h49,8'h29,8'h1e};
				8'h3a: g = {8'h00,8'h36,8'h36,8'h00,8'h00};
				8'h3b: g = {8'h00,8'h56,8'h36,8'h00,8'h00};
				8'h3c: g = {8'h08,8'h14,8'h22,8'h41,8'h00};
				8'h3d: g = {8'h14,8'h14,8'h14,8'h14,8'h14};
				8'h3e: g = {8'h00,8'h41,8'h22,8'h14,8'h08};
				8'h3f: g = {8'h02,8'h01,8'h51,8'h09,8'h06};
				8'h40: g = {8'h32,8'h49,8'h79,8'h41,8'h3e};
				8'h41: g = {8'h7e,8'h11,8'h11,8'h11,8'h7e};
				8'h42: g = {8'h7f,8'h49,8'h49,8'h49,8'h36};
				8'h43: g = {8'h3e,8'h41,8'h41,8'h41,8'h22};
				8'h44: g = {8'h7f,8'h41,8'h41,8'h22,8'h1c};
				8'h45: g = {8'h7f,8'h49,8'h49,8'h49,8'h41};
				8'h46: g = {8'h7f,8'h09,8'h09,8'h09,8'h01};
				8'h47: g = {8'h3e,8'h41,8'h49,8'h49,8'h7a};
				8'h48: g = {8'h7f,8'h08,8'h08,8'h08,8'h7f};
				8'h49: g = {8'h00,8'h41,8'h7f,8'h41,8'h00};
				8'h4a: g = {8'h20,8'h40,8'h41,8'h3f,8'h01};
				8'h4b: g = {8'h7f,8'h08,8'h14,8'h22,8'h41};
				8'h4c: g = {8'h7f,8'h40,8'h40,8'h40,8'h40};
				8'h4d: g = {8'h7f,8'h02,8'h0c,8'h02,8'h7f};
				8'h4e: g = {8'h7f,8'h04,8'h08,8'h10,8'h7f};
				8'h4f: g = {8'h3e,8'h41,8'h41,8'h41,8'h3e};
				8'h50: g = {8'h7f,8'h09,8'h09,8'h09,8'h06};
				8'h51: g = {8'h3e,8'h41,8'h51,8'h21,8'h5e};
				8'h52: g = {8'h7f,8'h09,8'h19,8'h29,8'h46};
				8'h53: g = {8'h46,8'h49,8'h49,8'h49,8'h31};
				8'h54: g = {8'h01,8'h01,8'h7f,8'h01,8'h01};
				8'h55: g = {8'h3f,8'h40,8'h40,8'h40,8'h3f};
				8'h56: g = {8'h1f,8'h20,8'h40,8'h20,8'h1f};
				8'h57: g = {8'h3f,8'h40,8'h38,8'h40,8'h3f};
				8'h58: g = {8'h63,8'h14,8'h08,8'h14,8'h63};
				8'h59: g = {8'h07,8'h08,8'h70,8'h08,8'h07};
				8'h5a: g = {8'h61,8'h51,8'h49,8'h45,8'h43};
				8'h5b: g = {8'h00,8'h7f,8'h41,8'h41,8'h00};
				8'h5c: g = {8'h02,8'h04,8'h08,8'h10,8'h20};
				8'h5d: g = {8'h00,8'h41,8'h41,8'h7f,8'h00};
				8'h5e: g = {8'h04,8'h02,8'h01,8'h02,8'h04};
				8'h5f: g = {8'h40,8'h40,8'h40,8'h40,8'h40};
				8'h60: g = {8'h00,8'h01,8'h02,8'h04,8'h00};
				8'h61: g = {8'h20,8'h54,8'h54,8'h54,8'h78};
				8'h62: g = {8'h7f,8'h48,8'h44,8'h44,8'h38};
				8'h63: g = {8'h38,8'h44,8'h44,8'h44,8'h20};
				8'h64: g = {8'h38,8'h44,8'h44,8'h48,8'h7f};
				8'h65: g = {8'h38,8'h54,8'h54,8'h54,8'h18};
				8'h66: g = {8'h08,8'h7e,8'h09,8'h01,8'h02};
				8'h67: g = {8'h0c,8'h52,8'h52,8'h52,8'h3e};
				8'h68: g = {8'h7f,8'h08,8'h04,8'h04,8'h78};
				8'h69: g = {8'h00,8'h44,8'h7d,8'h40,8'h00};
				8'h6a: g = {8'h20,8'h40,8'h44,8'h3d,8'h00};
				8'h6b: g = {8'h7f,8'h10,8'h28,8'h44,8'h00};
				8'h6c: g = {8'h00,8'h41,8'h7f,8'h40,8'h00};
				8'h6d: g = {8'h7c,8'h04,8'h18,8'h04,8'h78};
				8'h6e: g = {8'h7c,8'h08,8'h04,8'h04,8'h78};
				8'h6f: g = {8'h38,8'h44,8'h44,8'h44,8'h38};
				8'h70: g = {8'h7c,8'h14,8'h14,8'h14,8'h08};
				8'h71: g = {8'h08,8'h14,8'h14,8'h18,8'h7c};
				8'h72: g = {8'h7c,8'h08,8'h04,8'h04,8'h08};
				8'h73: g = {8'h48,8'h54,8'h54,8'h54,8'h20};
				8'h74: g = {8'h04,8'h3f,8'h44,8'h40,8'h20};
				8'h75: g = {8'h3c,8'h40,8'h40,8'h20,8'h7c};
				8'h76: g = {8'h1c,8'h20,8'h40,8'h20,8'h1c};
				8'h77: g = {8'h3c,8'h40,8'h30,8'h40,8'h3c};
				8'h78: g = {8'h44,8'h28,8'h10,8'h28,8'h44};
				8'h79: g = {8'h0c,8'h50,8'h50,8'h50,8'h3c};
				8'h7a: g = {8'h44,8'h64,8'h54,8'h4c,8'h44};
				8'h7b: g = {8'h00,8'h08,8'h36,8'h41,8'h00};
				8'h7c: g = {8'h00,8'h00,8'h7f,8'h00,8'h00};
				8'h7d: g = {8'h00,8'h41,8'h36,8'h08,8'h00};
				8'h7e: g = {8'h08,8'h04,8'h08,8'h10,8'h08};
				default: g = 40'h0;
			endcase
			if (c < FIRST_CODE || c > LAST_CODE) begin
				g = 40'h0;
			end
			return g;
		end
	endfunction

endpackage

FILE: hdl/mfde_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mfde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/mono_framebuffer_draw_engine.sv
// Channel    Handshake            Ports
// command    start && !busy       func pos_x pos_y rect_width rect_height pen char_code
// result     done (one cycle)     read_byte
//
// Depends on mfde_pkg and mfde_ram (the page-major frame store).
// Every command but clear touches the bytes of its clipped column and page range,
// each read, then modified and written back; an empty fill, a command clipped away
// entirely or the unused opcode goes straight to the result strobe.
// After reset a clearing pass writes all 1024 bytes, one a cycle, with busy high.
// The result strobe cannot be stalled; every command yields exactly one word.
module mono_framebuffer_draw_engine
	import mfde_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2:0]        func,
	input  logic signed [9:0] pos_x,
	input  logic signed [9:0] pos_y,
	input  logic [7:0]        rect_width,
	input  logic [7:0]        rect_height,
	input  logic              pen,
	input  logic [7:0]        char_code,
	output logic              busy,
	output logic              done,
	output logic [7:0]        read_byte
);

	localparam logic signed [CRD_W-1:0] X_MAX = CRD_W'(PANEL_WIDTH - 1);
	localparam logic signed [CRD_W-1:0] Y_MAX = CRD_W'(PANEL_HEIGHT - 1);
	localparam logic signed [CRD_W-1:0] Y_LIM = CRD_W'(PANEL_HEIGHT);

	state_t state_q, state_d;
	func_t  fn, op_q;
	logic   accept, last, we;

	logic signed [CRD_W-1:0] xs, ys, cl, ch, rl, rh, cl_c, ch_c, rl_c, rh_c;
	logic empty;

	logic signed [9:0]       x_q, y_q;
	logic signed [CRD_W-1:0] yend_q, pg0_q;
	logic                    pen_q;
	logic [39:0]             glyph_q;
	logic [7:0]              read_byte_q;
	logic [COL_W-1:0]        col_q, clo_q, chi_q;
	logic [PAGE_W-1:0]       page_q, phi_q;

	logic [ADDR_W-1:0]       addr;
	logic [7:0]              rdata, wdata, m, v;
	logic signed [CRD_W-1:0] dc, dp, ye;
	logic [2:0]              kc, sh;
	logic [39:0]             gsh;
	logic [7:0]              gcol;
	logic [15:0]             dbl, g16, m16;
	logic [23:0]             d24;
	logic signed [CRD_W-1:0] rowa [8];
	logic [7:0]              fm, rv;

	assign fn = func_t'(func);
	assign accept = start && !busy;

	always_comb begin
		xs = {{(CRD_W-10){pos_x[9]}}, pos_x};
		ys = {{(CRD_W-10){pos_y[9]}}, pos_y};
		cl = xs;
		ch = xs;
		rl = ys;
		rh = ys;
		empty = 1'b0;
		case (fn)
			FN_CHAR, FN_CHAR_INV: begin
				ch = xs + CRD_W'(CELL_COLS - 1);
				rh = ys + CRD_W'(7);
			end
			FN_CHAR_DBL: begin
				ch = xs + CRD_W'(2 * 5 - 1);
				rh = ys + CRD_W'(15);
			end
			FN_FILL: begin
				ch = xs + $signed({{(CRD_W-8){1'b0}}, rect_width}) - CRD_W'(1);
				rh = ys + $signed({{(CRD_W-8){1'b0}}, rect_height}) - CRD_W'(1);
				empty = (rect_width == 8'd0) || (rect_height == 8'd0);
			end
			FN_NONE: empty = 1'b1;
			default: ;
		endcase
		if (ch < 0 || cl > X_MAX || rh < 0 || rl > Y_MAX) begin
			empty = 1'b1;
		end
		cl_c = (cl < 0) ? '0 : cl;
		ch_c = (ch > X_MAX) ? X_MAX : ch;
		rl_c = (rl < 0) ? '0 : rl;
		rh_c = (rh > Y_MAX) ? Y_MAX : rh;
	end

	assign last = (col_q == chi_q) && (page_q == phi_q);
	assign addr = ADDR_W'(page_q) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(col_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: if (last) state_d = (op_q == FN_CLEAR) ? ST_DONE : ST_IDLE;
			ST_IDLE: begin
				if (start) begin
					if (fn == FN_CLEAR) state_d = ST_INIT;
					else if (empty) state_d = ST_DONE;
					else state_d = ST_RD;
				end
			end
			ST_RD: state_d = ST_WR;
			ST_WR: state_d = last ? ST_DONE : ST_RD;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_DONE);
		we = (state_q == ST_WR) || (state_q == ST_INIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			op_q <= FN_NONE;
			col_q <= '0;
			clo_q <= '0;
			chi_q <= COL_W'(PANEL_WIDTH - 1);
			page_q <= '0;
			phi_q <= PAGE_W'(PAGE_COUNT - 1);
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q <= fn;
				if (fn == FN_CLEAR) begin
					col_q <= '0;
					clo_q <= '0;
					chi_q <= COL_W'(PANEL_WIDTH - 1);
					page_q <= '0;
					phi_q <= PAGE_W'(PAGE_COUNT - 1);
				end else begin
					col_q <= cl_c[COL_W-1:0];
					clo_q <= cl_c[COL_W-1:0];
					chi_q <= ch_c[COL_W-1:0];
					page_q <= rl_c[3 +: PAGE_W];
					phi_q <= rh_c[3 +: PAGE_W];
				end
			end else if (we) begin
				if (col_q == chi_q) begin
					col_q <= clo_q;
					page_q <= page_q + PAGE_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= pos_x;
			y_q <= pos_y;
			pg0_q <= ys >>> 3;
			yend_q <= ys + $signed({{(CRD_W-8){1'b0}}, rect_height});
			pen_q <= pen;
			glyph_q <= font_glyph(char_code);
			read_byte_q <= 8'h00;
		end else if (state_q == ST_WR && op_q == FN_READ) begin
			read_byte_q <= rdata;
		end
	end

	assign read_byte = read_byte_q;

	always_comb begin
		ye = {{(CRD_W-10){y_q[9]}}, y_q};
		dc = $signed({{(CRD_W-COL_W){1'b0}}, col_q}) - $signed({{(CRD_W-10){x_q[9]}}, x_q});
		dp = $signed({{(CRD_W-PAGE_W){1'b0}}, page_q}) - pg0_q;
		kc = (op_q == FN_CHAR_DBL) ? dc[3:1] : dc[2:0];
		gsh = glyph_q << (6'(kc) * 6'd8);
		gcol = (kc < 3'd5) ? gsh[39:32] : SPACING_BITS;
		for (int i = 0; i < 8; i++) begin
			dbl[2*i +: 2] = {2{gcol[i]}};
			rowa[i] = $signed({{(CRD_W-PAGE_W-3){1'b0}}, page_q, 3'(i)});
			fm[i] = (rowa[i] >= ye) && (rowa[i] < yend_q);
			rv[i] = (rowa[i] < Y_LIM);
		end
		sh = y_q[2:0];
		g16 = {8'h00, gcol} << sh;
		m16 = 16'h00ff << sh;
		d24 = {8'h00, dbl} << sh;
		case (op_q)
			FN_PIXEL: begin
				m = 8'h01 << sh;
				v = pen_q ? m : 8'h00;
			end
			FN_CHAR: begin
				m = dp[0] ? m16[15:8] : m16[7:0];
				v = dp[0] ? g16[15:8] : g16[7:0];
			end
			FN_CHAR_INV: begin
				m = dp[0] ? m16[15:8] : m16[7:0];
				v = ~(dp[0] ? g16[15:8] : g16[7:0]);
			end
			FN_CHAR_DBL: begin
				m = (dp[1:0] == 2'd2) ? d24[23:16] : (dp[0] ? d24[15:8] : d24[7:0]);
				v = m;
			end
			FN_FILL: begin
				m = fm;
				v = pen_q ? m : 8'h00;
			end
			default: begin
				m = 8'h00;
				v = 8'h00;
			end
		endcase
		m = m & rv;
		wdata = (state_q == ST_INIT) ? 8'h00 : ((rdata & ~m) | (v & m));
	end

	mfde_ram #(
		.WIDTH(8),
		.DEPTH(STORE_SIZE)
	) u_store (
		.clk(clk),
		.we(we),
		.waddr(addr),
		.wdata(wdata),
		.raddr(addr),
		.rdata(rdata)
	);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("accepted command did not raise busy");
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q != FN_READ) |-> read_byte == 8'h00)
		else $error("nonzero result for a command other than read");
	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> $past(state_q) == ST_RD)
		else $error("write back without a preceding read");

endmodule

FILE: bench/mfde_checker.sv
// Checker for the monochrome frame buffer draw engine: keeps a shadow frame store,
// predicts the word of every accepted command and compares it with the result port.
// Depends on mfde_pkg.
module mfde_checker
	import mfde_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [2:0]        func,
	input  logic signed [9:0] pos_x,
	input  logic signed [9:0] pos_y,
	input  logic [7:0]        rect_width,
	input  logic [7:0]        rect_height,
	input  logic              pen,
	input  logic [7:0]        char_code,
	input  logic              done,
	input  logic [7:0]        read_byte,
	output int                fail_count,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0] shadow_store [STORE_SIZE];
	logic [7:0] byte_queue [$];
	logic [7:0] glyph_rom [95][5];

	initial begin
		glyph_rom = '{
			'{8'h00,8'h00,8'h00,8'h00,8'h00},'{8'h00,8'h00,8'h5f,8'h00,8'h00},
			'{8'h00,8'h07,8'h00,8'h07,8'h00},'{8'h14,8'h7f,8'h14,8'h7f,8'h14},
			'{8'h24,8'h2a,8'h7f,8'h2a,8'h12},'{8'h23,8'h13,8'h08,8'h64,8'h62},
			'{8'h36,8'h49,8'h55,8'h22,8'h50},'{8'h00,8'h05,8'h03,8'h00,8'h00},
			'{8'h00,8'h1c,8'h22,8'h41,8'h00},'{8'h00,8'h41,8'h22,8'h1c,8'h00},
			'{8'h14,8'h08,8'h3e,8'h08,8'h14},'{8'h08,8'h08,8'h3e,8'h08,8'h08},
			'{8'h00,8'h50,8'h30,8'h00,8'h00},'{8'h08,8'h08,8'h08,8'h08,8'h08},
			'{8'h00,8'h60,8'h60,8'h00,8'h00},'{8'h20,8'h10,8'h08,8'h04,8'h02},
			'{8'h3e,8'h51,8'h49,8'h45,8'h3e},'{8'h00,8'h42,8'h7f,8'h40,8'h00},
			'{8'h42,8'h61,8'h51,8'h49,8'h46},'{8'h21,8'h41,8'h45,8'h4b,8'h31},
			'{8'h18,8'h14,8'h12,8'h7f,8'h10},'{8'h27,8'h45,8'h45,8'h45,8'h39},
			'{8'h3c,8'h4a,8'h49,8'h49,8'h30},'{8'h01,8'h71,8'h09,8'h05,8'h03},
			'{8'h36,8'h49,8'h49,8'h49,8'h36},'{8'h06,8'h49,8'h49,8'h29,8'h1e},
			'{8'h00,8'h36,8'h36,8'h00,8'h00},'{8'h00,8'h56,8'h36,8'h00,8'h00},
			'{8'h08,8'h14,8'h22,8'h41,8'h00},'{8'h14,8'h14,8'h14,8'h14,8'h14},
			'{8'h00,8'h41,8'h22,8'h14,8'h08},'{8'h02,8'h01,8'h51,8'h09,8'h06},
			'{8'h32,8'h49,8'h79,8'h41,8'h3e},'{8'h7e,8'h11,8'h11,8'h11,8'h7e},
			'{8'h7f,8'h49,8'h49,8'h49,8'h36},'{8'h3e,8'h41,8'h41,8'h41,8'h22},
			'{8'h7f,8'h41,8'h41,8'h22,8'h1c},'{8'h7f,8'h49,8'h49,8'h49,8'h41},
			'{8'h7f,8'h09,8'h09,8'h09,8'h01},'{8'h3e,8'h41,8'h49,8'h49,8'h7a},
			'{8'h7f,8'h08,8'h08,8'h08,8'h7f},'{8'h00,8'h41,8'h7f,8'h41,8'h00},
			'{8'h20,8'h40,8'h41,8'h3f,8'h01},'{8'h7f,8'h08,8'h14,8'h22,8'h41},
			'{8'h7f,8'h40,8'h40,8'h40,8'h40},'{8'h7f,8'h02,8'h0c,8'h02,8'h7f},
			'{8'h7f,8'h04,8'h08,8'h10,8'h7f},'{8'h3e,8'h41,8'h41,8'h41,8'h3e},
			'{8'h7f,8'h09,8'h09,8'h09,8'h06},'{8'h3e,8'h41,8'h51,8'h21,8'h5e},
			'{8'h7f,8'h09,8'h19,8'h29,8'h46},'{8'h46,8'h49,8'h49,8'h49,8'h31},
			'{8'h01,8'h01,8'h7f,8'h01,8'h01},'{8'h3f,8'h40,8'h40,8'h40,8'h3f},
			'{8'h1f,8'h20,8'h40,8'h20,8'h1f},'{8'h3f,8'h40,8'h38,8'h40,8'h3f},
			'{8'h63,8'h14,8'h08,8'h14,8'h63},'{8'h07,8'h08,8'h70,8'h08,8'h07},
			'{8'h61,8'h51,8'h49,8'h45,8'h43},'{8'h00,8'h7f,8'h41,8'h41,8'h00},
			'{8'h02,8'h04,8'h08,8'h10,8'h20},'{8'h00,8'h41,8'h41,8'h7f,8'h00},
			'{8'h04,8'h02,8'h01,8'h02,8'h04},'{8'h40,8'h40,8'h40,8'h40,8'h40},
			'{8'h00,8'h01,8'h02,8'h04,8'h00},'{8'h20,8'h54,8'h54,8'h54,8'h78},
			'{8'h7f,8'h48,8'h44,8'h44,8'h38},'{8'h38,8'h44,8'h44,8'h44,8'h20},
			'{8'h38,8'h44,8'h44,8'h48,8'h7f},'{8'h38,8'h54,8'h54,8'h54,8'h18},
			'{8'h08,8'h7e,8'h09,8'h01,8'h02},'{8'h0c,8'h52,8'h52,8'h52,8'h3e},
			'{8'h7f,8'h08,8'h04,8'h04,8'h78},'{8'h00,8'h44,8'h7d,8'h40,8'h00},
			'{8'h20,8'h40,8'h44,8'h3d,8'h00},'{8'h7f,8'h10,8'h28,8'h44,8'h00},
			'{8'h00,8'h41,8'h7f,8'h40,8'h00},'{8'h7c,8'h04,8'h18,8'h04,8'h78},
			'{8'h7c,8'h08,8'h04,8'h04,8'h78},'{8'h38,8'h44,8'h44,8'h44,8'h38},
			'{8'h7c,8'h14,8'h14,8'h14,8'h08},'{8'h08,8'h14,8'h14,8'h18,8'h7c},
			'{8'h7c,8'h08,8'h04,8'h04,8'h08},'{8'h48,8'h54,8'h54,8'h54,8'h20},
			'{8'h04,8'h3f,8'h44,8'h40,8'h20},'{8'h3c,8'h40,8'h40,8'h20,8'h7c},
			'{8'h1c,8'h20,8'h40,8'h20,8'h1c},'{8'h3c,8'h40,8'h30,8'h40,8'h3c},
			'{8'h44,8'h28,8'h10,8'h28,8'h44},'{8'h0c,8'h50,8'h50,8'h50,8'h3c},
			'{8'h44,8'h64,8'h54,8'h4c,8'h44},'{8'h00,8'h08,8'h36,8'h41,8'h00},
			'{8'h00,8'h00,8'h7f,8'h00,8'h00},'{8'h00,8'h41,8'h36,8'h08,8'h00},
			'{8'h08,8'h04,8'h08,8'h10,8'h08}};
		foreach (shadow_store[i]) shadow_store[i] = 8'h00;
	end

	function automatic void plot(int x, int y, bit lit);
		int addr;
		if (x < 0 || x >= PANEL_WIDTH || y < 0 || y >= PANEL_HEIGHT) return;
		addr = (y / 8) * PANEL_WIDTH + x;
		shadow_store[addr][y % 8] = lit;
	endfunction

	function automatic int glyph_index(logic [7:0] code);
		if (code < FIRST_CODE || code > LAST_CODE) return 0;
		return int'(code - FIRST_CODE);
	endfunction

	function automatic logic [7:0] apply_command(func_t op, int x, int y, int w, int h,
			bit p, logic [7:0] code);
		int g;
		logic [7:0] bits;
		logic [7:0] word;
		g = glyph_index(code);
		word = 8'h00;
		case (op)
			FN_PIXEL: plot(x, y, p);
			FN_CHAR, FN_CHAR_INV: begin
				for (int c = 0; c < CELL_COLS; c++) begin
					bits = (c < 5) ? glyph_rom[g][c] : SPACING_BITS;
					for (int r = 0; r < 8; r++)
						plot(x + c, y + r, bits[r] ^ (op == FN_CHAR_INV));
				end
			end
			FN_CHAR_DBL: begin
				for (int c = 0; c < 5; c++)
					for (int r = 0; r < 8; r++)
						if (glyph_rom[g][c][r])
							for (int k = 0; k < 4; k++)
								plot(x + 2 * c + k % 2, y + 2 * r + k / 2, 1'b1);
			end
			FN_FILL: begin
				for (int yy = y; yy < y + h; yy++)
					for (int xx = x; xx < x + w; xx++)
						plot(xx, yy, p);
			end
			FN_CLEAR: foreach (shadow_store[i]) shadow_store[i] = 8'h00;
			FN_READ: begin
				if (x >= 0 && x < PANEL_WIDTH && y >= 0 && y < PANEL_HEIGHT)
					word = shadow_store[(y / 8) * PANEL_WIDTH + x];
			end
			default: ;
		endcase
		return word;
	endfunction

	task automatic report(string what, logic [7:0] got, logic [7:0] want);
		$display("mismatch: %s got %02h expected %02h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial fail_count = 0;
	assign pending = byte_queue.size();

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (byte_queue.size() == 0)
					report("unexpected word", read_byte, 8'h00);
				else if (read_byte !== byte_queue[0])
					report("read_byte", read_byte, byte_queue.pop_front());
				else
					void'(byte_queue.pop_front());
			end
			if (start && !busy)
				byte_queue.push_back(apply_command(func_t'(func), int'(pos_x), int'(pos_y),
					int'(rect_width), int'(rect_height), pen, char_code));
		end
	end
endmodule

FILE: bench/tb_top.sv
// Top of the draw engine testbench: drives commands with random gaps outside a calm
// stretch and reaches a verdict from the checker's failure and pending counts.
// Depends on mfde_pkg, mfde_checker and mono_framebuffer_draw_engine.
module tb_top
	import mfde_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic [2:0]        func;
	logic signed [9:0] pos_x;
	logic signed [9:0] pos_y;
	logic [7:0]        rect_width;
	logic [7:0]        rect_height;
	logic              pen;
	logic [7:0]        char_code;
	logic              busy;
	logic              done;
	logic [7:0]        read_byte;
	int                fail_count;
	int                pending;
	int                sent;
	int                reads_sent;

	mono_framebuffer_draw_engine u_top (.*);
	mfde_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("[mono_framebuffer_draw_engine] ERROR");
		$finish;
	end

	task automatic issue(func_t op, int x, int y, int w, int h, int p, int code,
			bit calm = 1'b0);
		if (!calm)
			while ($urandom_range(99) < 31) begin
				start <= 1'b0;
				@(posedge clk);
			end
		start       <= 1'b1;
		func        <= op;
		pos_x       <= x[9:0];
		pos_y       <= y[9:0];
		rect_width  <= w[7:0];
		rect_height <= h[7:0];
		pen         <= p[0];
		char_code   <= code[7:0];
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
		if (op == FN_READ) reads_sent++;
	endtask

	task automatic random_command(bit calm);
		int pick;
		int x;
		int y;
		pick = $urandom_range(99);
		x = $urandom_range(99) < 85 ? $urandom_range(PANEL_WIDTH + 7) - 8
			: $urandom_range(1023) - 512;
		y = $urandom_range(99) < 85 ? $urandom_range(PANEL_HEIGHT + 7) - 8
			: $urandom_range(1023) - 512;
		if (pick < 15)
			issue(FN_PIXEL, x, y, $urandom, $urandom, $urandom, $urandom, calm);
		else if (pick < 27)
			issue(FN_CHAR, x, y, $urandom, $urandom, $urandom, $urandom, calm);
		else if (pick < 37)
			issue(FN_CHAR_INV, x, y, $urandom, $urandom, $urandom, $urandom, calm);
		else if (pick < 46)
			issue(FN_CHAR_DBL, x, y, $urandom, $urandom, $urandom, $urandom, calm);
		else if (pick < 58)
			issue(FN_FILL, x, y, $urandom_range(99) < 90 ? $urandom_range(24) : $urandom,
				$urandom_range(99) < 90 ? $urandom_range(20) : $urandom, $urandom, $urandom,
				calm);
		else if (pick < 60)
			issue(FN_CLEAR, x, y, $urandom, $urandom, $urandom, $urandom, calm);
		else if (pick < 98)
			issue(FN_READ, x, y, $urandom, $urandom, $urandom, $urandom, calm);
		else
			issue(FN_NONE, x, y, $urandom, $urandom, $urandom, $urandom, calm);
	endtask

	initial begin
		int guard;
		arst_n = 1'b0;
		start = 1'b0;
		func = FN_PIXEL;
		pos_x = '0;
		pos_y = '0;
		rect_width = '0;
		rect_height = '0;
		pen = 1'b0;
		char_code = '0;
		sent = 0;
		reads_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(FN_PIXEL, 0, 0, 0, 0, 1, 0);
		issue(FN_PIXEL, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 255, 255, 1, 255);
		issue(FN_PIXEL, -512, 511, 0, 0, 1, 0);
		issue(FN_READ, 0, 0, 0, 0, 0, 0);
		issue(FN_READ, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 0, 0, 0, 0);
		issue(FN_CHAR, 3, 5, 0, 0, 0, 8'h41);
		issue(FN_CHAR_INV, PANEL_WIDTH - 3, PANEL_HEIGHT - 4, 0, 0, 0, 8'h7E);
		issue(FN_CHAR, -2, -3, 0, 0, 0, 8'h00);
		issue(FN_CHAR_INV, 20, 10, 0, 0, 0, 8'hFF);
		issue(FN_CHAR_DBL, 40, 20, 0, 0, 0, 8'h23);
		issue(FN_CHAR_DBL, PANEL_WIDTH - 5, PANEL_HEIGHT - 7, 0, 0, 0, 8'h20);
		issue(FN_FILL, 60, 30, 0, 10, 1, 0);
		issue(FN_FILL, 60, 30, 10, 0, 1, 0);
		issue(FN_FILL, -10, -10, 255, 255, 1, 0);
		issue(FN_FILL, 10, 10, 20, 12, 0, 0);
		issue(FN_READ, 12, 12, 0, 0, 0, 0);
		issue(FN_READ, 511, -1, 0, 0, 0, 0);
		issue(FN_NONE, 5, 5, 1, 1, 1, 1);
		issue(FN_CLEAR, 0, 0, 0, 0, 0, 0);
		issue(FN_READ, 12, 12, 0, 0, 0, 0);

		for (int i = 0; i < 1000; i++) begin
			random_command(i >= 300 && i < 450);
			if (i == 600) begin
				start <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end
		start <= 1'b0;

		guard = 0;
		while (pending != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (1100) @(posedge clk);
		$display("Sent %0d commands of every kind, %0d of them reads, with clipping,",
			sent, reads_sent);
		$display("empty fills, unprintable codes and unused opcodes mixed in.");
		if (fail_count == 0 && pending == 0)
			$display("[mono_framebuffer_draw_engine] OK");
		else
			$display("[mono_framebuffer_draw_engine] ERROR");
		$finish;
	end
endmodule

FILE: sim.f
hdl/mfde_pkg.sv
hdl/mfde_ram.sv
hdl/mono_framebuffer_draw_engine.sv
bench/mfde_checker.sv
bench/tb_top.sv
